>>> hw/rtl/assert_macros.svh
// Assertion macros for the RTL of the dual PWM driver, included by its top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// same-cycle implication, checked at every rising clock edge outside reset
`define DPWM_ASSERT_SAME(lbl, clk, rst, cond, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) else $error(msg);
// next-cycle implication, checked at every rising clock edge outside reset
`define DPWM_ASSERT_NEXT(lbl, clk, rst, cond, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);
`else
`define DPWM_ASSERT_SAME(lbl, clk, rst, cond, prop, msg)
`define DPWM_ASSERT_NEXT(lbl, clk, rst, cond, prop, msg)
`endif
`endif

>>> hw/rtl/dpwm_pkg.sv
// Types and constants shared by the dual PWM H-bridge driver.
`default_nettype none
package dpwm_pkg;

   localparam int WIDTH_BITS   = 20;
   localparam int FUNC_BITS    = 2;
   localparam int CHAN_BITS    = 2;
   localparam int VALUE_BITS   = 7;
   localparam int MAX_CHANNELS = 2;
   localparam int SEL_BITS     = 1;
   localparam int ADDR_BITS    = 5;
   localparam int DATA_BITS    = 32;
   localparam int INDEX_BITS   = 3;

   localparam logic [FUNC_BITS-1:0] FUNC_TICK    = 2'd0;
   localparam logic [FUNC_BITS-1:0] FUNC_DUTY    = 2'd1;
   localparam logic [FUNC_BITS-1:0] FUNC_DIR     = 2'd2;
   localparam logic [FUNC_BITS-1:0] FUNC_STANDBY = 2'd3;

   localparam logic [INDEX_BITS-1:0] REG_PERIOD = 3'd0;
   localparam logic [INDEX_BITS-1:0] REG_MIN_A  = 3'd1;
   localparam logic [INDEX_BITS-1:0] REG_MAX_A  = 3'd2;
   localparam logic [INDEX_BITS-1:0] REG_MIN_B  = 3'd3;
   localparam logic [INDEX_BITS-1:0] REG_MAX_B  = 3'd4;

   localparam logic [1:0] DIR_OFF = 2'b00;
   localparam logic [1:0] DIR_FWD = 2'b01;
   localparam logic [1:0] DIR_REV = 2'b10;

   localparam logic [WIDTH_BITS-1:0] DEFAULT_PERIOD    = 20'd1000000;
   localparam logic [WIDTH_BITS-1:0] DEFAULT_MIN_WIDTH = DEFAULT_PERIOD >> 7;

   localparam logic [VALUE_BITS-1:0] PCT_FULL = 7'd100;

   // |span| * pct stays below 2^27; multiply by ceil(2^34/100) and shift for an exact /100
   localparam int MAG_BITS    = 27;
   localparam int RECIP_BITS  = 28;
   localparam int RECIP_SHIFT = 34;
   localparam logic [RECIP_BITS-1:0] RECIP_FACTOR = 28'd171798692;

   typedef logic [WIDTH_BITS-1:0] width_type;

   typedef struct packed {
      width_type                    period_ticks;
      width_type [MAX_CHANNELS-1:0] min_width;
      width_type [MAX_CHANNELS-1:0] max_width;
   } cfg_type;

   typedef struct packed {
      logic [SEL_BITS-1:0] ch;
      logic                pct_zero;
      logic                value_nz;
      logic                neg;
      logic [MAG_BITS-1:0] mag;
   } scale_type;

endpackage
`default_nettype wire

>>> hw/rtl/dpwm_csr.sv
// Configuration register file with its APB-style access port.
`default_nettype none
module dpwm_csr
   import dpwm_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_psel,
   input  wire logic                 csr_penable,
   input  wire logic                 csr_pwrite,
   input  wire logic [ADDR_BITS-1:0] csr_paddr,
   input  wire logic [DATA_BITS-1:0] csr_pwdata,
   output      logic [DATA_BITS-1:0] csr_prdata,
   output      logic                 csr_pready,
   output      cfg_type              cfg
);

   cfg_type                 cfg_ff;
   cfg_type                 cfg_in;
   logic [INDEX_BITS-1:0]   index;
   logic                    write_en;
   width_type               wdata;
   width_type               rdata;

   assign index      = csr_paddr[ADDR_BITS-1:2];
   assign write_en   = csr_psel && csr_penable && csr_pwrite;
   assign wdata      = csr_pwdata[WIDTH_BITS-1:0];
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         case (index)
            REG_PERIOD: cfg_in.period_ticks = wdata;
            REG_MIN_A:  cfg_in.min_width[0] = wdata;
            REG_MAX_A:  cfg_in.max_width[0] = wdata;
            REG_MIN_B:  cfg_in.min_width[1] = wdata;
            REG_MAX_B:  cfg_in.max_width[1] = wdata;
            default:    cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (index)
         REG_PERIOD: rdata = cfg_ff.period_ticks;
         REG_MIN_A:  rdata = cfg_ff.min_width[0];
         REG_MAX_A:  rdata = cfg_ff.max_width[0];
         REG_MIN_B:  rdata = cfg_ff.min_width[1];
         REG_MAX_B:  rdata = cfg_ff.max_width[1];
         default:    rdata = '0;
      endcase
   end

   assign csr_prdata = DATA_BITS'(rdata);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.period_ticks <= DEFAULT_PERIOD;
         cfg_ff.min_width    <= {MAX_CHANNELS{DEFAULT_MIN_WIDTH}};
         cfg_ff.max_width    <= {MAX_CHANNELS{DEFAULT_PERIOD}};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule
`default_nettype wire

>>> hw/rtl/dpwm_scale.sv
// Front half of the duty mapping: channel clamp, percent saturation, span times percent.
`default_nettype none
module dpwm_scale
   import dpwm_pkg::*;
#(
   parameter int NUM_CHANNELS = 2
) (
   input  wire logic [CHAN_BITS-1:0]  channel,
   input  wire logic [VALUE_BITS-1:0] value,
   input  wire cfg_type               cfg,
   output      scale_type             scale
);

   logic [SEL_BITS-1:0]   sel;
   logic [VALUE_BITS-1:0] pct;
   logic [WIDTH_BITS:0]   diff;
   logic [WIDTH_BITS:0]   span_full;
   logic                  neg;

   always_comb begin
      // clamp out-of-range channels onto the last one
      if (channel >= CHAN_BITS'(NUM_CHANNELS)) begin
         sel = SEL_BITS'(NUM_CHANNELS - 1);
      end else begin
         sel = channel[SEL_BITS-1:0];
      end
      pct       = (value > PCT_FULL) ? PCT_FULL : value;
      diff      = {1'b0, cfg.max_width[sel]} - {1'b0, cfg.min_width[sel]};
      neg       = diff[WIDTH_BITS];
      span_full = neg ? ((WIDTH_BITS + 1)'(0) - diff) : diff;
   end

   assign scale.ch       = sel;
   assign scale.pct_zero = (pct == '0);
   assign scale.value_nz = (value != '0);
   assign scale.neg      = neg;
   assign scale.mag      = MAG_BITS'(span_full[WIDTH_BITS-1:0]) * MAG_BITS'(pct);

endmodule
`default_nettype wire

>>> hw/rtl/dpwm_recip.sv
// Back half of the duty mapping: divide by one hundred via reciprocal, apply sign, add low width.
`default_nettype none
module dpwm_recip
   import dpwm_pkg::*;
(
   input  wire width_type           lo,
   input  wire logic                neg,
   input  wire logic [MAG_BITS-1:0] mag,
   output      width_type           width
);

   logic [MAG_BITS+RECIP_BITS-1:0] prod;
   width_type                      quot;

   assign prod  = (MAG_BITS + RECIP_BITS)'(mag) * (MAG_BITS + RECIP_BITS)'(RECIP_FACTOR);
   assign quot  = prod[RECIP_SHIFT +: WIDTH_BITS];
   // quotient truncates toward zero, so the sign goes on after the divide
   assign width = neg ? (lo - quot) : (lo + quot);

endmodule
`default_nettype wire

>>> hw/rtl/dual_pwm_hbridge_driver_unit.sv
// Top level of the two-channel PWM generator for an H-bridge motor driver.
//
//  port group | direction | handshake            | carries
//  -----------+-----------+----------------------+-----------------------------------
//  req_*      | in        | req_valid/req_ready  | func, channel, value
//  rsp_*      | out       | rsp_valid/rsp_ready  | pwm levels, dir pins, standby, widths
//  csr_*      | in/out    | psel/penable/pready  | period and per-channel width range
//
// One word per clock unless the result side stalls: a word lands in the input register, passes
// through the duty mapping and state update and is then held in the result register. The
// span-times-percent multiply before the input register and the reciprocal multiply before
// the result register set the clock. Reset (synchronous, active high) clears the counter,
// levels, pins and standby, and loads the default period and widths. A stalled result holds
// both stages; req_ready then drops.
`default_nettype none
`include "assert_macros.svh"
module dual_pwm_hbridge_driver_unit
   import dpwm_pkg::*;
#(
   parameter int NUM_CHANNELS = 2,
   parameter int COUNT_BITS   = 20
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // input words
   input  wire logic                  req_valid,
   output      logic                  req_ready,
   input  wire logic [FUNC_BITS-1:0]  req_func,
   input  wire logic [CHAN_BITS-1:0]  req_channel,
   input  wire logic [VALUE_BITS-1:0] req_value,
   // result words
   output      logic                  rsp_valid,
   input  wire logic                  rsp_ready,
   output      logic                  rsp_pwm_a,
   output      logic                  rsp_pwm_b,
   output      logic                  rsp_a_in1,
   output      logic                  rsp_a_in2,
   output      logic                  rsp_b_in1,
   output      logic                  rsp_b_in2,
   output      logic                  rsp_standby_n,
   output      logic [WIDTH_BITS-1:0] rsp_width_a,
   output      logic [WIDTH_BITS-1:0] rsp_width_b,
   // configuration port
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [ADDR_BITS-1:0]  csr_paddr,
   input  wire logic [DATA_BITS-1:0]  csr_pwdata,
   output      logic [DATA_BITS-1:0]  csr_prdata,
   output      logic                  csr_pready
);

   // compare counter against 20-bit widths at the wider of the two sizes
   localparam int CMP_BITS = (COUNT_BITS > WIDTH_BITS) ? COUNT_BITS : WIDTH_BITS;

   cfg_type cfg;

   dpwm_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // ---------------------------------------------------------------- input register
   scale_type            scale;
   logic                 s1_valid_ff;
   logic                 s1_valid_in;
   logic [FUNC_BITS-1:0] s1_func_ff;
   scale_type            s1_scale_ff;
   logic                 take;
   logic                 advance;
   logic                 accept;

   dpwm_scale #(
      .NUM_CHANNELS (NUM_CHANNELS)
   ) u_scale (
      .channel (req_channel),
      .value   (req_value),
      .cfg     (cfg),
      .scale   (scale)
   );

   // result register free, or emptied this cycle
   assign take      = !rsp_valid || rsp_ready;
   assign advance   = s1_valid_ff && take;
   assign req_ready = !s1_valid_ff || take;
   assign accept    = req_valid && req_ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_func_ff  <= req_func;
         s1_scale_ff <= scale;
      end
   end

   // ---------------------------------------------------------------- duty mapping
   width_type new_width;

   dpwm_recip u_recip (
      .lo    (cfg.min_width[s1_scale_ff.ch]),
      .neg   (s1_scale_ff.neg),
      .mag   (s1_scale_ff.mag),
      .width (new_width)
   );

   // ---------------------------------------------------------------- driver state
   logic [COUNT_BITS-1:0] count_ff;
   logic [COUNT_BITS-1:0] count_in;
   width_type             pending_ff [NUM_CHANNELS];
   width_type             pending_in [NUM_CHANNELS];
   width_type             active_ff  [NUM_CHANNELS];
   width_type             active_in  [NUM_CHANNELS];
   logic [1:0]            dir_ff     [NUM_CHANNELS];
   logic [1:0]            dir_in     [NUM_CHANNELS];
   logic                  level_ff   [NUM_CHANNELS];
   logic                  level_in   [NUM_CHANNELS];
   logic                  standby_ff;
   logic                  standby_in;

   width_type             period_eff;
   logic [COUNT_BITS-1:0] count_start;
   logic [COUNT_BITS-1:0] count_step;

   always_comb begin
      // a zero period behaves as a period of one tick
      period_eff = (cfg.period_ticks == '0) ? WIDTH_BITS'(1) : cfg.period_ticks;
      // restart a count left at or past the period
      count_start = (CMP_BITS'(count_ff) >= CMP_BITS'(period_eff)) ? '0 : count_ff;
      count_step  = count_start + COUNT_BITS'(1);

      count_in   = count_ff;
      pending_in = pending_ff;
      active_in  = active_ff;
      dir_in     = dir_ff;
      level_in   = level_ff;
      standby_in = standby_ff;

      if (advance) begin
         case (s1_func_ff)
            FUNC_TICK: begin
               for (int i = 0; i < NUM_CHANNELS; i++) begin
                  // latch pending widths at the start of each period
                  if (count_start == '0) begin
                     active_in[i] = pending_ff[i];
                  end
                  level_in[i] = CMP_BITS'(count_start) < CMP_BITS'(active_in[i]);
               end
               count_in = (CMP_BITS'(count_step) >= CMP_BITS'(period_eff)) ? '0 : count_step;
            end
            FUNC_DUTY: begin
               for (int i = 0; i < NUM_CHANNELS; i++) begin
                  if (s1_scale_ff.ch == SEL_BITS'(i)) begin
                     if (s1_scale_ff.pct_zero) begin
                        dir_in[i]     = DIR_OFF;
                        pending_in[i] = cfg.min_width[i];
                     end else begin
                        pending_in[i] = new_width;
                     end
                  end
               end
               // any nonzero duty wakes the driver
               if (!s1_scale_ff.pct_zero) begin
                  standby_in = 1'b1;
               end
            end
            FUNC_DIR: begin
               for (int i = 0; i < NUM_CHANNELS; i++) begin
                  if (s1_scale_ff.ch == SEL_BITS'(i)) begin
                     dir_in[i] = s1_scale_ff.value_nz ? DIR_REV : DIR_FWD;
                  end
               end
            end
            FUNC_STANDBY: begin
               standby_in = s1_scale_ff.value_nz;
            end
            default: begin
               standby_in = standby_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         standby_ff <= 1'b0;
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            pending_ff[i] <= DEFAULT_MIN_WIDTH;
            active_ff[i]  <= DEFAULT_MIN_WIDTH;
            dir_ff[i]     <= DIR_OFF;
            level_ff[i]   <= 1'b0;
         end
      end else begin
         count_ff   <= count_in;
         pending_ff <= pending_in;
         active_ff  <= active_in;
         dir_ff     <= dir_in;
         level_ff   <= level_in;
         standby_ff <= standby_in;
      end
   end

   // ---------------------------------------------------------------- result register
   logic      out_valid_ff;
   logic      out_valid_in;
   logic      chb_level;
   logic [1:0] chb_dir;
   width_type chb_width;

   // channel B reads as zero in a single-channel build
   generate
      if (NUM_CHANNELS > 1) begin : g_chb
         assign chb_level = level_in[1];
         assign chb_dir   = dir_in[1];
         assign chb_width = pending_in[1];
      end else begin : g_no_chb
         assign chb_level = 1'b0;
         assign chb_dir   = DIR_OFF;
         assign chb_width = '0;
      end
   endgenerate

   always_comb begin
      out_valid_in = rsp_valid;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   // show the state after the word
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_pwm_a     <= level_in[0];
         rsp_pwm_b     <= chb_level;
         rsp_a_in1     <= dir_in[0][0];
         rsp_a_in2     <= dir_in[0][1];
         rsp_b_in1     <= chb_dir[0];
         rsp_b_in2     <= chb_dir[1];
         rsp_standby_n <= standby_in;
         rsp_width_a   <= pending_in[0];
         rsp_width_b   <= chb_width;
      end
   end

   assign rsp_valid = out_valid_ff;

   // ---------------------------------------------------------------- checks
   `DPWM_ASSERT_SAME(a_stall_blocks, clock, reset, s1_valid_ff && rsp_valid && !rsp_ready, !req_ready, "input taken while both stages are stalled")
   `DPWM_ASSERT_NEXT(a_accept_lands, clock, reset, accept, s1_valid_ff, "accepted word lost before the input register")
   `DPWM_ASSERT_NEXT(a_advance_shows, clock, reset, advance, rsp_valid, "advanced word missing from the result register")
   `DPWM_ASSERT_NEXT(a_duty_wakes, clock, reset, advance && s1_func_ff == FUNC_DUTY && !s1_scale_ff.pct_zero, rsp_standby_n, "nonzero duty left the driver in standby")

endmodule
`default_nettype wire

>>> tb/sv/dpwm_driver_checker.sv
// Checker for the dual PWM H-bridge driver: predicts every result word and compares it.
module dpwm_driver_checker
   import dpwm_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire logic                  req_ready,
   input  wire logic [FUNC_BITS-1:0]  req_func,
   input  wire logic [CHAN_BITS-1:0]  req_channel,
   input  wire logic [VALUE_BITS-1:0] req_value,
   input  wire logic                  rsp_valid,
   input  wire logic                  rsp_ready,
   input  wire logic                  rsp_pwm_a,
   input  wire logic                  rsp_pwm_b,
   input  wire logic                  rsp_a_in1,
   input  wire logic                  rsp_a_in2,
   input  wire logic                  rsp_b_in1,
   input  wire logic                  rsp_b_in2,
   input  wire logic                  rsp_standby_n,
   input  wire logic [WIDTH_BITS-1:0] rsp_width_a,
   input  wire logic [WIDTH_BITS-1:0] rsp_width_b,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [ADDR_BITS-1:0]  csr_paddr,
   input  wire logic [DATA_BITS-1:0]  csr_pwdata,
   input  wire logic                  csr_pready,
   output int                         fail_count,
   output int                         words_due,
   output int                         words_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic      pwm_a;
      logic      pwm_b;
      logic      a_in1;
      logic      a_in2;
      logic      b_in1;
      logic      b_in2;
      logic      standby_n;
      width_type width_a;
      width_type width_b;
   } pin_state_type;

   // settings
   width_type  period_reg;
   width_type  min_w [MAX_CHANNELS];
   width_type  max_w [MAX_CHANNELS];
   // driver state
   width_type  tick_count;
   width_type  pend_w [MAX_CHANNELS];
   width_type  act_w [MAX_CHANNELS];
   logic [1:0] dir_pins [MAX_CHANNELS];
   logic       level [MAX_CHANNELS];
   logic       standby;

   pin_state_type pin_states_due [$];
   int            fail_total = 0;
   int            checked_total = 0;

   initial begin
      fail_count    = 0;
      words_due     = 0;
      words_checked = 0;
   end

   // advance the driver by one input word and return the pins it leaves behind
   function automatic pin_state_type step_driver(input logic [FUNC_BITS-1:0]  func,
                                                 input logic [CHAN_BITS-1:0]  chan,
                                                 input logic [VALUE_BITS-1:0] val);
      int unsigned           sel;
      int unsigned           per;
      logic [VALUE_BITS-1:0] pct;
      longint                lo;
      longint                hi;
      pin_state_type         pins;
      sel = (chan >= MAX_CHANNELS) ? MAX_CHANNELS - 1 : chan;
      case (func)
         FUNC_TICK: begin
            per = (period_reg == '0) ? 1 : period_reg;
            if (tick_count >= per) tick_count = '0;
            if (tick_count == '0) begin
               for (int c = 0; c < MAX_CHANNELS; c++) act_w[c] = pend_w[c];
            end
            for (int c = 0; c < MAX_CHANNELS; c++) level[c] = (tick_count < act_w[c]);
            tick_count = tick_count + 1'b1;
            if (tick_count >= per) tick_count = '0;
         end
         FUNC_DUTY: begin
            pct = (val > PCT_FULL) ? PCT_FULL : val;
            if (pct == '0) begin
               dir_pins[sel] = DIR_OFF;
               pend_w[sel]   = min_w[sel];
            end else begin
               lo = longint'(min_w[sel]);
               hi = longint'(max_w[sel]);
               pend_w[sel] = width_type'(lo + ((hi - lo) * longint'(pct)) / 100);
               standby     = 1'b1;
            end
         end
         FUNC_DIR: dir_pins[sel] = (val != '0) ? DIR_REV : DIR_FWD;
         default: standby = (val != '0);
      endcase
      pins.pwm_a     = level[0];
      pins.pwm_b     = level[1];
      pins.a_in1     = dir_pins[0][0];
      pins.a_in2     = dir_pins[0][1];
      pins.b_in1     = dir_pins[1][0];
      pins.b_in2     = dir_pins[1][1];
      pins.standby_n = standby;
      pins.width_a   = pend_w[0];
      pins.width_b   = pend_w[1];
      return pins;
   endfunction

   function automatic void compare_field(input string field, input width_type got,
                                         input width_type want);
      if (got !== want) begin
         fail_total++;
         if (fail_total <= REPORT_LIMIT)
            $display("%0t: %s wrong in result word %0d: expected 0x%0h, got 0x%0h",
                     $realtime, field, checked_total, want, got);
      end
   endfunction

   always @(posedge clock) begin : track
      pin_state_type due;
      if (reset) begin
         period_reg = DEFAULT_PERIOD;
         tick_count = '0;
         standby    = 1'b0;
         for (int c = 0; c < MAX_CHANNELS; c++) begin
            min_w[c]    = DEFAULT_MIN_WIDTH;
            max_w[c]    = DEFAULT_PERIOD;
            pend_w[c]   = DEFAULT_MIN_WIDTH;
            act_w[c]    = DEFAULT_MIN_WIDTH;
            dir_pins[c] = DIR_OFF;
            level[c]    = 1'b0;
         end
         pin_states_due.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[ADDR_BITS-1:2])
               REG_PERIOD: period_reg = csr_pwdata[WIDTH_BITS-1:0];
               REG_MIN_A:  min_w[0]   = csr_pwdata[WIDTH_BITS-1:0];
               REG_MAX_A:  max_w[0]   = csr_pwdata[WIDTH_BITS-1:0];
               REG_MIN_B:  min_w[1]   = csr_pwdata[WIDTH_BITS-1:0];
               REG_MAX_B:  max_w[1]   = csr_pwdata[WIDTH_BITS-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            pin_states_due.push_back(step_driver(req_func, req_channel, req_value));
         if (rsp_valid && rsp_ready) begin
            if (pin_states_due.size() == 0) begin
               fail_total++;
               if (fail_total <= REPORT_LIMIT)
                  $display("%0t: result word arrived with no input word behind it", $realtime);
            end else begin
               due = pin_states_due.pop_front();
               compare_field("pwm_a", width_type'(rsp_pwm_a), width_type'(due.pwm_a));
               compare_field("pwm_b", width_type'(rsp_pwm_b), width_type'(due.pwm_b));
               compare_field("a_in1", width_type'(rsp_a_in1), width_type'(due.a_in1));
               compare_field("a_in2", width_type'(rsp_a_in2), width_type'(due.a_in2));
               compare_field("b_in1", width_type'(rsp_b_in1), width_type'(due.b_in1));
               compare_field("b_in2", width_type'(rsp_b_in2), width_type'(due.b_in2));
               compare_field("standby_n", width_type'(rsp_standby_n),
                             width_type'(due.standby_n));
               compare_field("width_a", rsp_width_a, due.width_a);
               compare_field("width_b", rsp_width_b, due.width_b);
               checked_total++;
            end
         end
      end
      fail_count    <= fail_total;
      words_due     <= pin_states_due.size();
      words_checked <= checked_total;
   end

endmodule

>>> tb/sv/tb_dual_pwm_hbridge_driver_unit.sv
// Regression top for the dual PWM H-bridge driver: stimulus, flow control and verdict.
module tb_dual_pwm_hbridge_driver_unit
   import dpwm_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int        WATCHDOG_LIMIT  = 2000;  // quiet cycles before giving up
   localparam int        PHASE_COUNT     = 12;    // random phases, one setting each
   localparam int        WORDS_PER_PHASE = 128;
   localparam int        DRAIN_CYCLES    = 8;
   localparam width_type WIDTH_TOP       = '1;
   localparam logic [INDEX_BITS-1:0] UNMAPPED_REG = REG_MAX_B + 1'b1;

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [FUNC_BITS-1:0]  req_func = FUNC_TICK;
   logic [CHAN_BITS-1:0]  req_channel = '0;
   logic [VALUE_BITS-1:0] req_value = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic                  rsp_pwm_a;
   logic                  rsp_pwm_b;
   logic                  rsp_a_in1;
   logic                  rsp_a_in2;
   logic                  rsp_b_in1;
   logic                  rsp_b_in2;
   logic                  rsp_standby_n;
   logic [WIDTH_BITS-1:0] rsp_width_a;
   logic [WIDTH_BITS-1:0] rsp_width_b;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [ADDR_BITS-1:0]  csr_paddr = '0;
   logic [DATA_BITS-1:0]  csr_pwdata = '0;
   logic [DATA_BITS-1:0]  csr_prdata;
   logic                  csr_pready;

   int fail_count;
   int words_due;
   int words_checked;

   // idle odds in percent; the stimulus process moves them between phases
   int sender_idle_pct   = 38;
   int receiver_idle_pct = 72;

   int words_sent    = 0;
   int reg_writes    = 0;
   int settings_used = 0;
   int quiet_cycles  = 0;

   dual_pwm_hbridge_driver_unit i_dut (.*);

   dpwm_driver_checker i_checker (.*);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Stall the result side at random; redraw every cycle so that stalls land on
   // every phase of the pipeline, including back-to-back stretches.
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= receiver_idle_pct);
   end

   // Watchdog: any handshake, register access or reset counts as progress.
   always @(posedge clock) begin
      if (reset || csr_psel || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("dual_pwm_hbridge_driver_unit regression: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Offer one input word. Idle first at the sender's odds, then hold valid and
   // the payload steady until the block takes the word. Valid stays high on
   // return so that a following word can go out on the very next edge.
   task automatic send_word(input logic [FUNC_BITS-1:0]  func,
                            input logic [CHAN_BITS-1:0]  chan,
                            input logic [VALUE_BITS-1:0] val);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_func    <= func;
      req_channel <= chan;
      req_value   <= val;
      do @(posedge clock); while (!req_ready);
      words_sent++;
   endtask

   // Drop valid and wait until every outstanding result word is back. The
   // first edge is always taken, since the checker's count is a registered copy.
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (words_due != 0);
   endtask

   // Setup cycle, then access cycle; the register takes the data at the edge
   // that sees psel, penable, pwrite and pready together. Junk goes into the
   // unused upper data bits, which the block must drop. Psel then drops and the task idles
   // before returning, so the next access starts with a fresh setup.
   task automatic write_reg(input logic [INDEX_BITS-1:0] index, input width_type data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= {(DATA_BITS - WIDTH_BITS)'($urandom), data};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      reg_writes++;
   endtask

   task automatic load_setting(input width_type period, input width_type min_a,
                               input width_type max_a, input width_type min_b,
                               input width_type max_b);
      write_reg(REG_PERIOD, period);
      write_reg(REG_MIN_A, min_a);
      write_reg(REG_MAX_A, max_a);
      write_reg(REG_MIN_B, min_b);
      write_reg(REG_MAX_B, max_b);
      settings_used++;
   endtask

   // Mostly widths around the period, so outputs toggle inside it; now and
   // then a rail value so the duty mapping sees the full range.
   function automatic width_type pick_width(input int unsigned per);
      if ($urandom_range(7) == 0) return ($urandom_range(1) != 0) ? WIDTH_TOP : '0;
      return width_type'($urandom_range(per + 4));
   endfunction

   initial begin
      logic [FUNC_BITS-1:0]  func;
      logic [VALUE_BITS-1:0] val;
      int unsigned           per;
      int unsigned           pick;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed words under the reset setting: long period, default widths.
      send_word(FUNC_TICK, 2'd0, 7'd0);       // first tick latches the default widths
      send_word(FUNC_DUTY, 2'd0, 7'd0);       // zero percent: pins off, minimum width
      send_word(FUNC_DUTY, 2'd1, 7'd100);     // full duty releases standby
      send_word(FUNC_DUTY, 2'd3, 7'd127);     // out-of-range channel, saturated percent
      send_word(FUNC_DUTY, 2'd2, 7'd1);
      send_word(FUNC_DUTY, 2'd0, 7'd50);
      send_word(FUNC_DIR, 2'd0, 7'd0);
      send_word(FUNC_DIR, 2'd1, 7'd127);
      send_word(FUNC_DIR, 2'd3, 7'd1);
      send_word(FUNC_DUTY, 2'd1, 7'd0);       // zero percent clears channel B pins
      send_word(FUNC_STANDBY, 2'd0, 7'd0);
      send_word(FUNC_STANDBY, 2'd3, 7'd127);
      send_word(FUNC_STANDBY, 2'd2, 7'd0);
      send_word(FUNC_DUTY, 2'd0, 7'd64);      // nonzero duty lifts standby again

      // Zero period, zero and full widths, and a downward range on channel B.
      // Also poke an address past the last register, which must change nothing.
      settle();
      load_setting('0, '0, WIDTH_TOP, WIDTH_TOP, '0);
      write_reg(UNMAPPED_REG, width_type'(20'd3));
      send_word(FUNC_TICK, 2'd3, 7'd127);
      send_word(FUNC_DUTY, 2'd0, 7'd100);
      send_word(FUNC_DUTY, 2'd1, 7'd37);
      send_word(FUNC_TICK, 2'd0, 7'd0);
      send_word(FUNC_TICK, 2'd1, 7'd85);
      send_word(FUNC_DUTY, 2'd2, 7'd0);
      send_word(FUNC_DUTY, 2'd0, 7'd0);        // width zero: output low all period
      send_word(FUNC_TICK, 2'd2, 7'd42);
      send_word(FUNC_TICK, 2'd0, 7'd0);

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         // swap the idle odds a third of the way in, then run flat out
         if (phase == PHASE_COUNT / 3) begin
            sender_idle_pct   = 72;
            receiver_idle_pct = 38;
         end else if (phase == 2 * PHASE_COUNT / 3) begin
            sender_idle_pct   = 0;
            receiver_idle_pct = 0;
         end
         settle();
         case (phase)
            0: load_setting(width_type'(1), '0, width_type'(1), width_type'(1), '0);
            1: load_setting(width_type'(7), '0, width_type'(9), width_type'(8), width_type'(2));
            2: load_setting(WIDTH_TOP, width_type'(3), width_type'(60), WIDTH_TOP, '0);
            3: load_setting(width_type'(12), width_type'(12), '0, width_type'(5), width_type'(5));
            default: begin
               per = $urandom_range(30, 1);
               load_setting(width_type'(per), pick_width(per), pick_width(per),
                            pick_width(per), pick_width(per));
            end
         endcase

         // Ticks dominate so the short periods wrap many times; commands are
         // mixed in with percents biased toward zero and the saturated band.
         repeat (WORDS_PER_PHASE) begin
            pick = $urandom_range(99);
            if (pick < 60) func = FUNC_TICK;
            else if (pick < 80) func = FUNC_DUTY;
            else if (pick < 90) func = FUNC_DIR;
            else func = FUNC_STANDBY;
            case ($urandom_range(3))
               0: val = '0;
               1: val = VALUE_BITS'($urandom_range(127, 100));
               default: val = VALUE_BITS'($urandom_range(127));
            endcase
            send_word(func, CHAN_BITS'($urandom_range(3)), val);
         end
      end

      // Drain, then give any stray result word time to show up.
      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d input words over %0d driver settings (%0d register writes)",
               words_sent, settings_used, reg_writes);
      $display("compared %0d result words field by field; %0d faults found",
               words_checked, fail_count);
      if (fail_count == 0 && words_due == 0) begin
         $display("dual_pwm_hbridge_driver_unit regression: pass");
      end else begin
         $display("dual_pwm_hbridge_driver_unit regression: fail");
      end
      $finish;
   end

endmodule
